// ----- design/astat_pkg.sv -----
// ----------------------------------------------------------------------------
// Array stream statistics package
// Item types, status groups and constants shared by the statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package astat_pkg;

  // Field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIGIT_W = 22;
  localparam int unsigned DSUM_W  = 6;   // digit sum of one value, at most 38

  // Trial-division unit widths
  localparam int unsigned MAG_W = VALUE_W - 1;  // magnitude of a positive value
  localparam int unsigned DIV_W = 8;            // odd divisor, at most 183
  localparam int unsigned SQ_W  = 16;           // divisor squared, at most 33489

  // Saturation limits
  localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};
  localparam logic [DIGIT_W-1:0] DIGIT_CAP = {DIGIT_W{1'b1}};

  // Reset value of the running maxima
  localparam logic signed [VALUE_W-1:0] MAX_INIT = -16'sd1;

  // Division by ten: q = (n * RECIP_10) >> RECIP_SHIFT, exact for 16-bit n
  localparam int unsigned        RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_10    = 16'd52429;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam int unsigned        QUOT_W      = 12;  // quotient of 15-bit value by ten

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] largest;
    logic        [COUNT_W-1:0] primes_seen;
    logic        [DIGIT_W-1:0] digit_total;
    logic signed [VALUE_W-1:0] largest_even;
    logic signed [VALUE_W-1:0] largest_prime;
  } out_item_t;

  // Status of the primality unit
  typedef struct packed {
    logic done;
    logic prime;
  } prime_st_t;

  // Status of the digit-sum unit
  typedef struct packed {
    logic              done;
    logic [DSUM_W-1:0] sum;
  } digit_st_t;

endpackage

`default_nettype wire

// ----- design/astat_prime_unit.sv -----
// ----------------------------------------------------------------------------
// Primality unit
// Trial division by odd divisors up to the integer square root. One shared
// remainder step handles eight dividend bits a cycle, high byte then low byte.
// ----------------------------------------------------------------------------
`default_nettype none

module astat_prime_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [astat_pkg::VALUE_W-1:0] value,
  output astat_pkg::prime_st_t                   status
);
  import astat_pkg::*;

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic              prime_r, prime_nxt;
  logic              half_r,  half_nxt;
  logic [MAG_W-1:0]  n_r,     n_nxt;
  logic [DIV_W-1:0]  d_r,     d_nxt;
  logic [SQ_W-1:0]   sq_r,    sq_nxt;
  logic [DIV_W-1:0]  rem_r,   rem_nxt;

  logic [VALUE_W-1:0] dividend;
  logic [DIV_W-1:0]   step_byte;
  logic [DIV_W-1:0]   step_acc;
  logic [DIV_W:0]     step_tmp;
  logic [DIV_W-1:0]   step_rem;
  logic               sq_over;

  // Shared remainder step: eight restoring-division bits
  assign dividend  = {1'b0, n_r};
  assign step_byte = half_r ? dividend[DIV_W-1:0] : dividend[VALUE_W-1:DIV_W];

  always_comb begin
    step_acc = half_r ? rem_r : '0;
    step_tmp = '0;
    for (int i = 0; i < DIV_W; i++) begin
      step_tmp = {step_acc, step_byte[DIV_W-1-i]};
      if (step_tmp >= {1'b0, d_r}) begin
        step_tmp = step_tmp - {1'b0, d_r};
      end
      step_acc = step_tmp[DIV_W-1:0];
    end
    step_rem = step_acc;
  end

  // Divisor square already beyond the value: no divisor left
  assign sq_over = (sq_r > {1'b0, n_r});

  // Sequence the divisors
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    prime_nxt = prime_r;
    half_nxt  = half_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    if (start) begin
      n_nxt    = value[MAG_W-1:0];
      d_nxt    = DIV_W'(3);
      sq_nxt   = SQ_W'(9);
      half_nxt = 1'b0;
      priority if (value < $signed(VALUE_W'(2))) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        prime_nxt = 1'b0;
      end else if (value == $signed(VALUE_W'(2))) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        prime_nxt = 1'b1;
      end else if (!value[0]) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        prime_nxt = 1'b0;
      end else begin
        busy_nxt  = 1'b1;
        done_nxt  = 1'b0;
        prime_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (!half_r) begin
        if (sq_over) begin
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
        end else begin
          rem_nxt  = step_rem;
          half_nxt = 1'b1;
        end
      end else begin
        half_nxt = 1'b0;
        if (step_rem == '0) begin
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
          prime_nxt = 1'b0;
        end else begin
          // (d + 2)^2 = d^2 + 4d + 4
          d_nxt  = d_r + DIV_W'(2);
          sq_nxt = sq_r + SQ_W'({d_r, 2'b00}) + SQ_W'(4);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      half_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
  end

  assign status.done  = done_r;
  assign status.prime = prime_r;

endmodule

`default_nettype wire

// ----- design/astat_digit_unit.sv -----
// ----------------------------------------------------------------------------
// Digit-sum unit
// Peels one decimal digit a cycle off a positive value by a reciprocal
// multiply and adds it up.
// ----------------------------------------------------------------------------
`default_nettype none

module astat_digit_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [astat_pkg::VALUE_W-1:0] value,
  output astat_pkg::digit_st_t                   status
);
  import astat_pkg::*;

  localparam int unsigned PROD_W = MAG_W + RECIP_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MAG_W-1:0]  n_r,    n_nxt;
  logic [DSUM_W-1:0] sum_r,  sum_nxt;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [MAG_W-1:0]  tens;
  logic [3:0]        digit;

  // Split off the low digit
  assign prod  = PROD_W'(n_r) * PROD_W'(RECIP_10);
  assign quot  = prod[RECIP_SHIFT +: QUOT_W];
  assign tens  = MAG_W'({quot, 3'b000}) + MAG_W'({quot, 1'b0});
  assign digit = 4'(n_r - tens);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    n_nxt    = n_r;
    sum_nxt  = sum_r;
    if (start) begin
      n_nxt   = value[MAG_W-1:0];
      sum_nxt = '0;
      if (value > $signed(VALUE_W'(0))) begin
        busy_nxt = 1'b1;
        done_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      sum_nxt = sum_r + DSUM_W'(digit);
      n_nxt   = MAG_W'(quot);
      if (quot == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    sum_r <= sum_nxt;
  end

  assign status.done = done_r;
  assign status.sum  = sum_r;

endmodule

`default_nettype wire

// ----- design/array_stream_statistics.sv -----
// ----------------------------------------------------------------------------
// Array stream statistics
// Running maximum, prime count, largest prime, largest even value and
// decimal digit total over a list of signed 16-bit items.
// ----------------------------------------------------------------------------
// One item is in work at a time. After an item is taken, in_stall stays high
// until both units are done and the item is folded into the running totals;
// the next item can be taken in the cycle after that. For a value of zero or
// below both units are done straight from the start. The digit sum peels one
// digit a cycle off a positive value. The trial-division unit uses a
// remainder step of eight bits a cycle: for an odd value of three or more it
// tests each odd divisor from three up to its first factor, or all odd
// divisors up to its square root when it is prime. The longest item is 32761
// (181 squared). The item marked last delivers one result item through an
// output register and clears the running totals; an item may be taken while
// that result waits, but a following last item waits for the output register
// to free.
// ----------------------------------------------------------------------------
`default_nettype none

module array_stream_statistics (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire astat_pkg::in_item_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      astat_pkg::out_item_t out_data
);
  import astat_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  logic                      last_r;
  logic signed [VALUE_W-1:0] value_r;

  logic signed [VALUE_W-1:0] max_r,       max_nxt;
  logic        [COUNT_W-1:0] count_r,     count_nxt;
  logic        [DIGIT_W-1:0] dsum_r,      dsum_nxt;
  logic signed [VALUE_W-1:0] max_even_r,  max_even_nxt;
  logic signed [VALUE_W-1:0] max_prime_r, max_prime_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  logic      in_accept;
  logic      finish;
  prime_st_t prime_st;
  digit_st_t digit_st;

  logic signed [VALUE_W-1:0] upd_max;
  logic        [COUNT_W-1:0] upd_count;
  logic        [DIGIT_W-1:0] upd_dsum;
  logic        [DIGIT_W:0]   dsum_wide;
  logic signed [VALUE_W-1:0] upd_max_even;
  logic signed [VALUE_W-1:0] upd_max_prime;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);

  // Start both units on the accepted item
  astat_prime_unit u_prime (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .value  (in_data.value),
    .status (prime_st)
  );

  astat_digit_unit u_digit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .value  (in_data.value),
    .status (digit_st)
  );

  // Hold the item while the units work
  always_ff @(posedge clk) begin
    if (in_accept) begin
      value_r <= in_data.value;
      last_r  <= in_data.last;
    end
  end

  // Finish once both units are done and a last item has room to leave
  assign finish = (state_r == ST_RUN) && prime_st.done && digit_st.done &&
                  !(last_r && out_valid_r && out_stall);

  // Fold the item into the running totals
  always_comb begin
    upd_max       = (value_r > max_r) ? value_r : max_r;
    upd_count     = count_r;
    upd_max_prime = max_prime_r;
    if (prime_st.prime) begin
      if (count_r != COUNT_CAP) begin
        upd_count = count_r + COUNT_W'(1);
      end
      if (value_r > max_prime_r) begin
        upd_max_prime = value_r;
      end
    end
    upd_max_even = (!value_r[0] && (value_r > max_even_r)) ? value_r : max_even_r;
    dsum_wide    = {1'b0, dsum_r} + (DIGIT_W + 1)'(digit_st.sum);
    upd_dsum     = dsum_wide[DIGIT_W] ? DIGIT_CAP : dsum_wide[DIGIT_W-1:0];
  end

  // Sequence, totals and output register
  always_comb begin
    state_nxt     = state_r;
    max_nxt       = max_r;
    count_nxt     = count_r;
    dsum_nxt      = dsum_r;
    max_even_nxt  = max_even_r;
    max_prime_nxt = max_prime_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.largest       = upd_max;
            out_data_nxt.primes_seen   = upd_count;
            out_data_nxt.digit_total   = upd_dsum;
            out_data_nxt.largest_even  = upd_max_even;
            out_data_nxt.largest_prime = upd_max_prime;
            max_nxt       = MAX_INIT;
            count_nxt     = '0;
            dsum_nxt      = '0;
            max_even_nxt  = MAX_INIT;
            max_prime_nxt = MAX_INIT;
          end else begin
            max_nxt       = upd_max;
            count_nxt     = upd_count;
            dsum_nxt      = upd_dsum;
            max_even_nxt  = upd_max_even;
            max_prime_nxt = upd_max_prime;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= MAX_INIT;
      count_r     <= '0;
      dsum_r      <= '0;
      max_even_r  <= MAX_INIT;
      max_prime_r <= MAX_INIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      dsum_r      <= dsum_nxt;
      max_even_r  <= max_even_nxt;
      max_prime_r <= max_prime_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/astat_checker.sv -----
// ----------------------------------------------------------------------------
// Array stream statistics checker
// Port-level assertions on the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module astat_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire astat_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire astat_pkg::out_item_t out_data
);
  import astat_pkg::*;

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // One item at a time: the port closes after each taken item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // No prime counted exactly when the largest prime is still at its start
  a_prime_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.primes_seen == '0) == (out_data.largest_prime == MAX_INIT)))
    else $error("prime count and largest prime disagree");

  // The overall maximum bounds the even and prime maxima
  a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.largest >= out_data.largest_even) &&
                  (out_data.largest >= out_data.largest_prime))
    else $error("largest value below a partial maximum");

endmodule

bind array_stream_statistics astat_checker u_astat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
